// ----- rtl/core/kct_pkg.sv -----
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and codes for the keyed count table: request and response
// words, status codes, controller states and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

	// command codes
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// response status codes
	localparam logic [2:0] STAT_UPDATED   = 3'd0;
	localparam logic [2:0] STAT_INSERTED  = 3'd1;
	localparam logic [2:0] STAT_FREED     = 3'd2;
	localparam logic [2:0] STAT_BAD_TAG   = 3'd3;
	localparam logic [2:0] STAT_IGNORED   = 3'd4;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd5;
	localparam logic [2:0] STAT_FULL      = 3'd6;

	localparam int unsigned COUNT_W   = 31;
	localparam int unsigned TAG_IN_W  = 16;
	localparam int unsigned AMOUNT_W  = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic                       cmd;
		logic [TAG_IN_W-1:0]        tag_id;
		logic signed [AMOUNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COUNT_W-1:0] count_after;
		logic               saturated;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic match_en;
		logic exec_en;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_stall;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/kct_ctrl.sv -----
// ----------------------------------------------------------------------------
// kct_ctrl
// Sequencer for the keyed count table: accept, match and read, update.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  kct_pkg::dp_status_t dp_status,
	output kct_pkg::ctrl_cmd_t  ctrl_cmd
);
	import kct_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nxt = S_MATCH;
			end
			S_MATCH: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (!dp_status.rsp_stall) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready         = 1'b0;
		ctrl_cmd.load_req = 1'b0;
		ctrl_cmd.match_en = 1'b0;
		ctrl_cmd.exec_en  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready         = 1'b1;
				ctrl_cmd.load_req = req_valid;
			end
			S_MATCH: begin
				ctrl_cmd.match_en = 1'b1;
			end
			S_EXEC: begin
				ctrl_cmd.exec_en = !dp_status.rsp_stall;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/kct_dpath.sv -----
// ----------------------------------------------------------------------------
// kct_dpath
// Datapath: request registers, tag and valid flops with parallel match,
// count memory, update arithmetic and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_dpath #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned TAG_BITS    = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  kct_pkg::req_t       req,
	input  kct_pkg::ctrl_cmd_t  ctrl_cmd,
	output kct_pkg::dp_status_t dp_status,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output kct_pkg::rsp_t       rsp
);
	import kct_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

	// request word
	logic                cmd_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [AMOUNT_W-1:0] amt_q;
	logic [31:0]         tag_ext;

	// table
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TAG_BITS-1:0]    tag_arr_q [TABLE_DEPTH];
	logic [COUNT_W-1:0]     count_mem [TABLE_DEPTH];

	// match results
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] free_vec;
	logic [TABLE_DEPTH-1:0] free_first;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;
	logic                   hit_q;
	logic                   free_any_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [COUNT_W-1:0]     cur_q;

	// update
	logic               tag_zero;
	logic               amt_ignored;
	logic [COUNT_W-1:0] raw;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] diff;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [COUNT_W-1:0] wr_data;
	logic               set_valid;
	logic               clr_valid;
	rsp_t               rsp_nxt;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	assign tag_ext = {{(32 - TAG_IN_W){1'b0}}, req.tag_id};

	always_ff @(posedge clk) begin
		if (ctrl_cmd.load_req) begin
			cmd_q <= req.cmd;
			tag_q <= tag_ext[TAG_BITS-1:0];
			amt_q <= req.amount;
		end
	end

	// compare all entries; at most one valid entry holds a given tag
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (tag_arr_q[i] == tag_q);
		end
		free_vec   = ~valid_q;
		free_first = free_vec & (~free_vec + 1'b1);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit_vec[i])    hit_idx  = hit_idx  | IDX_W'(i);
			if (free_first[i]) free_idx = free_idx | IDX_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.match_en) begin
			hit_q      <= |hit_vec;
			free_any_q <= |free_vec;
			hit_idx_q  <= hit_idx;
			free_idx_q <= free_idx;
		end
	end

	assign tag_zero    = (tag_q == '0);
	assign amt_ignored = (amt_q == '0) || amt_q[AMOUNT_W-1];
	assign raw         = amt_q[COUNT_W-1:0];
	assign sum         = {1'b0, cur_q} + {1'b0, raw};
	assign diff        = cur_q - raw;

	always_comb begin
		rsp_nxt.status      = STAT_UPDATED;
		rsp_nxt.count_after = '0;
		rsp_nxt.saturated   = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = hit_idx_q;
		wr_data   = '0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		priority if (tag_zero) begin
			rsp_nxt.status = STAT_BAD_TAG;
		end else if (amt_ignored) begin
			rsp_nxt.status      = STAT_IGNORED;
			rsp_nxt.count_after = hit_q ? cur_q : '0;
		end else if (cmd_q == CMD_ADD) begin
			if (hit_q) begin
				wr_en = 1'b1;
				if (sum[COUNT_W]) begin
					wr_data           = COUNT_MAX;
					rsp_nxt.saturated = 1'b1;
				end else begin
					wr_data = sum[COUNT_W-1:0];
				end
				rsp_nxt.count_after = wr_data;
			end else if (free_any_q) begin
				wr_en               = 1'b1;
				wr_idx              = free_idx_q;
				wr_data             = raw;
				set_valid           = 1'b1;
				rsp_nxt.status      = STAT_INSERTED;
				rsp_nxt.count_after = raw;
			end else begin
				rsp_nxt.status = STAT_FULL;
			end
		end else begin
			if (!hit_q) begin
				rsp_nxt.status = STAT_NOT_FOUND;
			end else if (cur_q <= raw) begin
				clr_valid      = 1'b1;
				rsp_nxt.status = STAT_FREED;
			end else begin
				wr_en               = 1'b1;
				wr_data             = diff;
				rsp_nxt.count_after = diff;
			end
		end
	end

	// count memory: read during match, write during update
	always_ff @(posedge clk) begin
		if (ctrl_cmd.match_en) begin
			cur_q <= count_mem[hit_idx];
		end
		if (ctrl_cmd.exec_en && wr_en) begin
			count_mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.exec_en && set_valid) begin
			tag_arr_q[wr_idx] <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl_cmd.exec_en) begin
			if (set_valid) valid_q[wr_idx] <= 1'b1;
			if (clr_valid) valid_q[wr_idx] <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl_cmd.exec_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_cmd.exec_en) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign dp_status.rsp_stall = rsp_valid_q && !rsp_ready;
	assign rsp_valid           = rsp_valid_q;
	assign rsp                 = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/core/keyed_count_table.sv -----
// ----------------------------------------------------------------------------
// keyed_count_table
// Table of tags with saturating positive counts: add raises or inserts,
// remove lowers or frees; one response word per request word.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | word
//   ---------+-----------------------+-----------------------------------
//   request  | req_valid / req_ready | req : cmd, tag_id, amount
//   response | rsp_valid / rsp_ready | rsp : status, count_after, saturated
//
// each request passes three steps: accept, parallel tag match with count memory
// read, then update and load of the response register; the next request is
// accepted only after the update of the one before
// a held response stretches the update step until the register frees up
// reset clears all valid bits at once; no clearing pass, first request can
// be accepted right after reset
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_count_table #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned TAG_BITS    = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  kct_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output kct_pkg::rsp_t  rsp
);
	import kct_pkg::*;

	// command and status between the sequencer and the datapath
	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	// sequencer: idle, match, update
	kct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.dp_status (dp_status),
		.ctrl_cmd  (ctrl_cmd)
	);

	// tag flops, count memory and response register
	kct_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctrl_cmd  (ctrl_cmd),
		.dp_status (dp_status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/core/kct_checker.sv -----
// ----------------------------------------------------------------------------
// kct_checker
// Port-level checks for the keyed count table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           req_valid,
	input wire           req_ready,
	input kct_pkg::req_t req,
	input wire           rsp_valid,
	input wire           rsp_ready,
	input kct_pkg::rsp_t rsp
);
	import kct_pkg::*;

	// held response word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted twice in a row");

	// clipping only on an update, and then at the maximum
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.saturated |->
			rsp.status == STAT_UPDATED && rsp.count_after == COUNT_MAX)
		else $error("saturated without a clipped count");

	// absent or freed tags report a zero count
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_FREED || rsp.status == STAT_BAD_TAG ||
			rsp.status == STAT_NOT_FOUND || rsp.status == STAT_FULL) |->
			rsp.count_after == '0 && !rsp.saturated)
		else $error("nonzero count for absent tag");

	// an inserted entry holds a positive count
	a_insert_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_INSERTED |-> rsp.count_after != '0)
		else $error("inserted with zero count");

endmodule

bind keyed_count_table kct_checker u_kct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ----- sim/tb_keyed_count_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_count_table
// Self-checking bench for the keyed count table. A scoreboard keeps its own
// copy of the tag table, predicts the response word for every accepted
// request word and compares it field by field with the block's output.
// Stimulus is a short directed list of the corner cases, then a table fill and
// sweep, then random traffic over tag pools of two sizes, with bursty request
// timing and a response side that stalls in shifting patterns.
// ----------------------------------------------------------------------------

class count_table_scoreboard #(int unsigned DEPTH = 64, int unsigned TBITS = 16);

	bit               live[DEPTH];
	logic [TBITS-1:0] tag_of[DEPTH];
	logic [30:0]      count_of[DEPTH];
	kct_pkg::rsp_t    owed[$];
	int unsigned      errors;
	int unsigned      checked;
	int unsigned      status_hits[7];
	int unsigned      clipped_adds;

	function int find_tag(logic [TBITS-1:0] tag);
		for (int i = 0; i < DEPTH; i++)
			if (live[i] && tag_of[i] == tag)
				return i;
		return -1;
	endfunction

	function int find_free();
		for (int i = 0; i < DEPTH; i++)
			if (!live[i])
				return i;
		return -1;
	endfunction

	// updates the table copy and returns the response word it owes
	function kct_pkg::rsp_t apply_request(kct_pkg::req_t w);
		logic [TBITS-1:0] tag;
		logic [31:0]      raw;
		logic [32:0]      sum;
		int               hit;
		int               slot;
		kct_pkg::rsp_t    r;
		tag = w.tag_id[TBITS-1:0];
		raw = w.amount;
		r = '0;
		if (tag == '0) begin
			r.status = kct_pkg::STAT_BAD_TAG;
		end else begin
			hit = find_tag(tag);
			if (raw == '0 || raw[31]) begin
				r.status = kct_pkg::STAT_IGNORED;
				if (hit >= 0)
					r.count_after = count_of[hit];
			end else if (w.cmd == kct_pkg::CMD_ADD) begin
				if (hit >= 0) begin
					sum = {2'b00, count_of[hit]} + {1'b0, raw};
					if (sum > {2'b00, kct_pkg::COUNT_MAX}) begin
						sum = {2'b00, kct_pkg::COUNT_MAX};
						r.saturated = 1'b1;
					end
					count_of[hit] = sum[30:0];
					r.count_after = sum[30:0];
					r.status = kct_pkg::STAT_UPDATED;
				end else begin
					slot = find_free();
					if (slot >= 0) begin
						live[slot] = 1'b1;
						tag_of[slot] = tag;
						count_of[slot] = raw[30:0];
						r.count_after = raw[30:0];
						r.status = kct_pkg::STAT_INSERTED;
					end else begin
						r.status = kct_pkg::STAT_FULL;
					end
				end
			end else begin
				if (hit < 0) begin
					r.status = kct_pkg::STAT_NOT_FOUND;
				end else if ({1'b0, count_of[hit]} <= raw) begin
					live[hit] = 1'b0;
					r.status = kct_pkg::STAT_FREED;
				end else begin
					count_of[hit] = count_of[hit] - raw[30:0];
					r.count_after = count_of[hit];
					r.status = kct_pkg::STAT_UPDATED;
				end
			end
		end
		return r;
	endfunction

	function void note_request(kct_pkg::req_t w);
		owed.push_back(apply_request(w));
	endfunction

	function void check_response(kct_pkg::rsp_t got);
		kct_pkg::rsp_t want;
		if (owed.size() == 0) begin
			$display("%0t: response word with none expected: status %0d count %0d sat %0d",
				$time, got.status, got.count_after, got.saturated);
			errors++;
			return;
		end
		want = owed.pop_front();
		checked++;
		if (want.status < 7)
			status_hits[want.status]++;
		if (want.saturated)
			clipped_adds++;
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			errors++;
		end
		if (got.count_after !== want.count_after) begin
			$display("%0t: count_after expected %0d actual %0d",
				$time, want.count_after, got.count_after);
			errors++;
		end
		if (got.saturated !== want.saturated) begin
			$display("%0t: saturated expected %0d actual %0d",
				$time, want.saturated, got.saturated);
			errors++;
		end
	endfunction

	function int pending();
		return owed.size();
	endfunction

endclass

module tb_keyed_count_table;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned TAG_BITS    = 16;
	// cycles with no word moving on either side before the run is called hung
	localparam int unsigned IDLE_LIMIT  = 4000;
	localparam int unsigned POOL_MAX    = 96;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	kct_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	kct_pkg::rsp_t rsp;

	count_table_scoreboard #(TABLE_DEPTH, TAG_BITS) sb = new;

	// sender pacing
	int unsigned burst_left    = 0;
	bit          steady_sender = 1'b0;
	int unsigned words_sent    = 0;

	// response side stall pattern
	logic [31:0] rx_cyc  = '0;
	logic [1:0]  rx_mode = '0;

	int unsigned idle_cycles = 0;

	logic [15:0] tag_pool[POOL_MAX];
	logic [15:0] fill_tags[$];

	keyed_count_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.TAG_BITS   (TAG_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// response side: the stall pattern is redrawn each time the low seven bits of
	// rx_cyc wrap, among always ready, random stalls, heavy stalls and a fixed duty cycle
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (rx_cyc[6:0] == '0)
			rx_mode <= 2'($urandom_range(0, 3));
		case (rx_mode)
			2'd0: rsp_ready <= 1'b1;
			2'd1: rsp_ready <= 1'($urandom_range(0, 1));
			2'd2: rsp_ready <= ($urandom_range(0, 4) == 0);
			default: rsp_ready <= (rx_cyc[2:0] < 3'd3);
		endcase
	end

	// response monitor: every word taken is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d responses outstanding",
					$time, IDLE_LIMIT, sb.pending());
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic kct_pkg::req_t word_of(logic c, logic [15:0] t, logic [31:0] a);
		kct_pkg::req_t w;
		w.cmd = c;
		w.tag_id = t;
		w.amount = a;
		return w;
	endfunction

	// amount mix: mostly small counts so removes free entries, some near the
	// top to push adds into saturation, some zero or negative, some raw noise
	function automatic logic [31:0] pick_amount();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(1, 1000);
		else if (roll < 70)
			return $urandom_range(1, 8000);
		else if (roll < 78)
			return $urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF);
		else if (roll < 84)
			return $urandom_range(1, 32'h7FFF_FFFF);
		else if (roll < 90)
			return $urandom();
		else if (roll < 95)
			return '0;
		else
			return 32'd0 - 32'($urandom_range(1, 1000));
	endfunction

	// called on a rising edge; returns on the edge that takes the word
	task automatic send_word(input kct_pkg::req_t w);
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(w);
		words_sent++;
	endtask

	// bursts of random length with random gaps in between
	task automatic pace();
		int unsigned gap;
		if (steady_sender)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 14);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// hold the request side until every predicted response has been taken
	task automatic wait_all_responses();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_request(int unsigned pool_n, int unsigned add_pct);
		int unsigned   roll;
		logic [15:0]   tag;
		logic          c;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			tag = tag_pool[$urandom_range(0, pool_n - 1)];
		else if (roll < 94)
			tag = 16'($urandom_range(0, 16'hFFFF));
		else
			tag = '0;
		c = ($urandom_range(0, 99) < add_pct) ? kct_pkg::CMD_ADD : kct_pkg::CMD_REMOVE;
		send_word(word_of(c, tag, pick_amount()));
		pace();
	endtask

	initial begin
		logic [15:0] t;
		foreach (tag_pool[i])
			tag_pool[i] = 16'($urandom_range(1, 16'hFFFF));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad tag wins over a bad amount, ignored amounts on absent
		// and present tags, insert, saturation, exact and excess frees, reuse
		steady_sender = 1'b1;
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0000, 32'd5));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h0000, 32'hFFFF_FFFF));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0001, 32'd0));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0001, 32'hFFFF_FFFF));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0001, 32'h8000_0000));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h0001, 32'd5));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0001, 32'd1));
		send_word(word_of(kct_pkg::CMD_ADD,    16'hFFFF, 32'h7FFF_FFFF));
		send_word(word_of(kct_pkg::CMD_ADD,    16'hFFFF, 32'h7FFF_FFFF));
		send_word(word_of(kct_pkg::CMD_ADD,    16'hFFFF, 32'd1));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0001, 32'd0));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h0001, 32'h8000_0000));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h0001, 32'd10));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h0001, 32'd3));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h0001, 32'd8));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h0001, 32'd1));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'hFFFF, 32'h7FFF_FFFF));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h8000, 32'd100));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h8000, 32'h7FFF_FFFF));
		send_word(word_of(kct_pkg::CMD_ADD,    16'h5555, 32'h7FFF_FFFF));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h5555, 32'd1));
		send_word(word_of(kct_pkg::CMD_REMOVE, 16'h5555, 32'h7FFF_FFFF));
		wait_all_responses();

		// fill the table past its depth so inserts run into a full table,
		// then sweep every filled tag back out
		steady_sender = 1'b0;
		repeat (72) begin
			t = 16'($urandom_range(1, 16'hFFFF));
			fill_tags.push_back(t);
			send_word(word_of(kct_pkg::CMD_ADD, t, 32'($urandom_range(1, 50))));
			pace();
		end
		foreach (fill_tags[i]) begin
			send_word(word_of(kct_pkg::CMD_REMOVE, fill_tags[i], 32'h7FFF_FFFF));
			pace();
		end
		wait_all_responses();

		// small pool: lots of hits on updates and frees
		repeat (700)
			random_request(40, 55);
		wait_all_responses();

		// large pool, add heavy: table fills and full responses show up
		repeat (800)
			random_request(POOL_MAX, 65);
		wait_all_responses();

		// back to back requests with no sender gaps
		steady_sender = 1'b1;
		repeat (250)
			random_request(POOL_MAX, 50);
		wait_all_responses();

		repeat (20) @(posedge clk);
		$display("%0d request words sent, %0d responses checked, %0d mismatches",
			words_sent, sb.checked, sb.errors);
		$display("updated %0d inserted %0d freed %0d bad tag %0d ignored %0d not found %0d full %0d clipped %0d",
			sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
			sb.status_hits[4], sb.status_hits[5], sb.status_hits[6], sb.clipped_adds);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
